FILE: sv/lcmb_pkg.sv
`default_nettype none

package lcmb_pkg;

    localparam int LED_COUNT    = 32;
    localparam int HALF_COUNT   = LED_COUNT / 2;
    localparam int BLINK_CYCLES = 5;

    localparam int MODE_W     = 3;
    localparam int STEP_W     = 7;
    localparam int DWELL_W    = 10;
    localparam int DEB_W      = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 10;

    typedef logic [LED_COUNT-1:0]  led_t;
    typedef logic [MODE_W-1:0]     mode_t;
    typedef logic [STEP_W-1:0]     step_t;
    typedef logic [DWELL_W-1:0]    dwell_t;
    typedef logic [DEB_W-1:0]      deb_t;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam mode_t MODE_FIRST     = 3'd1;
    localparam mode_t MODE_FILL_LOW  = 3'd2;
    localparam mode_t MODE_FILL_HIGH = 3'd4;
    localparam mode_t MODE_BOTH_ENDS = 3'd5;
    localparam mode_t MODE_MIDDLE    = 3'd7;
    localparam mode_t MODE_LAST      = 3'd7;

    localparam cfg_addr_t CFG_BLINK_DWELL = 2'd0;
    localparam cfg_addr_t CFG_SHIFT_DWELL = 2'd1;
    localparam cfg_addr_t CFG_DEBOUNCE    = 2'd2;

    localparam dwell_t BLINK_DWELL_RST = 10'd500;
    localparam dwell_t SHIFT_DWELL_RST = 10'd100;
    localparam deb_t   DEBOUNCE_RST    = 8'd20;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEBOUNCE,
        PH_RELEASE
    } phase_t;

    // One pattern step: the new LED word, the two half-shifters and the step count.
    typedef struct packed {
        led_t  led;
        led_t  left;
        led_t  right;
        step_t step;
    } pat_t;

    function automatic logic is_blink(input mode_t m);
        return (m != MODE_FILL_LOW) && (m != MODE_FILL_HIGH) &&
               (m != MODE_BOTH_ENDS) && (m != MODE_MIDDLE);
    endfunction

endpackage

`default_nettype wire

FILE: sv/lcmb_pattern.sv
`default_nettype none

module lcmb_pattern (
    input  lcmb_pkg::mode_t mode_i,
    input  lcmb_pkg::step_t step_i,
    input  lcmb_pkg::led_t  led_i,
    input  lcmb_pkg::led_t  left_i,
    input  lcmb_pkg::led_t  right_i,
    output lcmb_pkg::pat_t  pat_o
);
    import lcmb_pkg::*;

    localparam led_t RIGHT_MASK = {{(LED_COUNT-HALF_COUNT){1'b0}}, {HALF_COUNT{1'b1}}};
    localparam led_t LEFT_MASK  = ~RIGHT_MASK;
    localparam led_t TOP_BIT    = led_t'(1) << (LED_COUNT - 1);
    localparam led_t MID_HI     = led_t'(1) << HALF_COUNT;
    localparam led_t MID_LO     = led_t'(1) << (HALF_COUNT - 1);

    localparam step_t BLINK_STEPS = step_t'(2 * BLINK_CYCLES);
    localparam step_t FULL_STEPS  = step_t'(2 * LED_COUNT);
    localparam step_t HALF_STEPS  = step_t'(2 * HALF_COUNT);

    step_t steps;
    step_t cur;
    led_t  led_b;
    led_t  left_b;
    led_t  right_b;
    logic  fill_full;
    logic  fill_half;

    always_comb begin
        if (is_blink(mode_i)) begin
            steps = BLINK_STEPS;
        end else if (mode_i == MODE_FILL_LOW || mode_i == MODE_FILL_HIGH) begin
            steps = FULL_STEPS;
        end else begin
            steps = HALF_STEPS;
        end

        // A finished pass starts over from step zero with a dark word.
        cur = (step_i >= steps) ? '0 : step_i;
        if (cur == '0) begin
            led_b   = '0;
            left_b  = '0;
            right_b = '0;
        end else begin
            led_b   = led_i;
            left_b  = left_i;
            right_b = right_i;
        end

        fill_full = cur < step_t'(LED_COUNT);
        fill_half = cur < step_t'(HALF_COUNT);

        pat_o.left  = left_b;
        pat_o.right = right_b;
        pat_o.step  = cur + step_t'(1);

        case (mode_i)
            MODE_FILL_LOW: begin
                pat_o.led = (led_b << 1) | led_t'(fill_full);
            end
            MODE_FILL_HIGH: begin
                pat_o.led = (led_b >> 1) | (fill_full ? TOP_BIT : '0);
            end
            MODE_BOTH_ENDS: begin
                if (fill_half) begin
                    pat_o.left  = (left_b >> 1) | TOP_BIT;
                    pat_o.right = (right_b << 1) | led_t'(1);
                end else begin
                    pat_o.left  = (left_b >> 1) & LEFT_MASK;
                    pat_o.right = (right_b << 1) & RIGHT_MASK;
                end
                pat_o.led = pat_o.left | pat_o.right;
            end
            MODE_MIDDLE: begin
                if (fill_half) begin
                    pat_o.left  = (left_b << 1) | MID_HI;
                    pat_o.right = (right_b >> 1) | MID_LO;
                end else begin
                    pat_o.left  = (left_b << 1) & LEFT_MASK;
                    pat_o.right = (right_b >> 1) & RIGHT_MASK;
                end
                pat_o.led = pat_o.left | pat_o.right;
            end
            default: begin
                pat_o.led = cur[0] ? '0 : '1;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/led_chaser_with_mode_button_top.sv
`default_nettype none
// The result beat for a tick is registered and appears in the cycle after the tick beat is taken.
// Throughput: one tick beat per cycle when not stalled; the state update is a single registered pass.
// A new tick beat is taken in the cycle the previous result beat leaves; a stalled result holds input.
// Reset (aresetn low, synchronous): mode 1, pattern not started, debounce idle,
// dwell and debounce registers back to 500, 100 and 20 ticks, no result pending.

module led_chaser_with_mode_button_top (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [7:0]                  s_tdata,   // [0] button_pressed
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [39:0]                 m_tdata,   // [31:0] led_word, [34:32] mode
    input  wire                         cfg_wr_en,
    input  wire  lcmb_pkg::cfg_addr_t   cfg_addr,
    input  wire  lcmb_pkg::cfg_data_t   cfg_wdata
);
    import lcmb_pkg::*;

    dwell_t blink_dwell_reg;
    dwell_t shift_dwell_reg;
    deb_t   debounce_reg;

    mode_t  mode_reg,   mode_next;
    led_t   led_reg,    led_next;
    led_t   left_reg,   left_next;
    led_t   right_reg,  right_next;
    step_t  step_reg,   step_next;
    dwell_t dwell_reg,  dwell_next;
    phase_t phase_reg,  phase_next;
    deb_t   deb_cnt_reg, deb_cnt_next;

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    logic   accept;
    logic   pressed;
    logic   idle_run;
    logic   press_eff;
    logic   emit;
    step_t  step_base;
    dwell_t dwell_base;
    dwell_t dwell_after;
    dwell_t dwell_lim;
    deb_t   deb_lim;
    deb_t   deb_inc;
    pat_t   pat;

    function automatic dwell_t dwell_sat_inc(input dwell_t d);
        return (d == '1) ? d : d + dwell_t'(1);
    endfunction

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign pressed  = s_tdata[0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    lcmb_pattern u_pattern (
        .mode_i  (mode_reg),
        .step_i  (step_base),
        .led_i   (led_reg),
        .left_i  (left_reg),
        .right_i (right_reg),
        .pat_o   (pat)
    );

    always_comb begin
        mode_next    = mode_reg;
        led_next     = led_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        step_next    = step_reg;
        dwell_next   = dwell_reg;
        phase_next   = phase_reg;
        deb_cnt_next = deb_cnt_reg;

        idle_run   = 1'b0;
        press_eff  = pressed;
        step_base  = step_reg;
        dwell_base = dwell_reg;

        dwell_lim = is_blink(mode_reg) ? blink_dwell_reg : shift_dwell_reg;
        if (dwell_lim == '0) begin
            dwell_lim = dwell_t'(1);
        end
        deb_lim = (debounce_reg == '0) ? deb_t'(1) : debounce_reg;
        deb_inc = (deb_cnt_reg == '1) ? deb_cnt_reg : deb_cnt_reg + deb_t'(1);

        if (accept) begin
            unique case (phase_reg)
                PH_DEBOUNCE: begin
                    deb_cnt_next = deb_inc;
                    if (deb_inc >= deb_lim) begin
                        if (pressed) begin
                            mode_next  = (mode_reg >= MODE_LAST) ? MODE_FIRST
                                                                 : mode_reg + mode_t'(1);
                            phase_next = PH_RELEASE;
                        end else begin
                            // A bounce: the window ends and counts as one dwell tick.
                            phase_next = PH_IDLE;
                            dwell_next = dwell_sat_inc(dwell_reg);
                        end
                    end
                end
                PH_RELEASE: begin
                    if (!pressed) begin
                        // Restart the new mode's pattern and show its first step now.
                        phase_next = PH_IDLE;
                        step_base  = '0;
                        dwell_base = '0;
                        press_eff  = 1'b0;
                        idle_run   = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    idle_run   = 1'b1;
                end
            endcase
        end

        emit        = (step_base == '0) || (dwell_base >= dwell_lim);
        dwell_after = emit ? '0 : dwell_base;

        if (idle_run) begin
            if (emit) begin
                led_next   = pat.led;
                left_next  = pat.left;
                right_next = pat.right;
                step_next  = pat.step;
            end else begin
                step_next  = step_base;
            end
            if (press_eff) begin
                phase_next   = PH_DEBOUNCE;
                deb_cnt_next = '0;
                dwell_next   = dwell_after;
            end else begin
                dwell_next   = dwell_sat_inc(dwell_after);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_dwell_reg <= BLINK_DWELL_RST;
            shift_dwell_reg <= SHIFT_DWELL_RST;
            debounce_reg    <= DEBOUNCE_RST;
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_BLINK_DWELL) begin
                blink_dwell_reg <= cfg_wdata;
            end else if (cfg_addr == CFG_SHIFT_DWELL) begin
                shift_dwell_reg <= cfg_wdata;
            end else if (cfg_addr == CFG_DEBOUNCE) begin
                debounce_reg    <= cfg_wdata[DEB_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_FIRST;
            led_reg      <= '0;
            left_reg     <= '0;
            right_reg    <= '0;
            step_reg     <= '0;
            dwell_reg    <= '0;
            phase_reg    <= PH_IDLE;
            deb_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            led_reg     <= led_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            step_reg    <= step_next;
            dwell_reg   <= dwell_next;
            phase_reg   <= phase_next;
            deb_cnt_reg <= deb_cnt_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {5'b0, mode_next, led_next};
        end
    end

endmodule

`default_nettype wire

FILE: bench/led_chaser_with_mode_button_top_tb.sv
module led_chaser_with_mode_button_top_tb;
    import lcmb_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int DIR_ROW_COUNT = 24;
    localparam int PHASE_COUNT   = 6;

    localparam led_t LEFT_MASK  = 32'hFFFF_0000;
    localparam led_t RIGHT_MASK = 32'h0000_FFFF;
    localparam led_t ALL_ON     = 32'hFFFF_FFFF;
    localparam led_t TOP_BIT    = 32'h8000_0000;
    localparam led_t MID_UP     = 32'h0001_0000;
    localparam led_t MID_DOWN   = 32'h0000_8000;

    localparam mode_t MODE_BLINK_B = 3'd3;
    localparam mode_t MODE_BLINK_C = 3'd6;

    // The fourth register index decodes to nothing.
    localparam cfg_addr_t CFG_UNUSED = 2'd3;

    // Timing settings per random phase; the last phase picks its own at random.
    localparam cfg_data_t PHASE_BLINK    [PHASE_COUNT] = '{10'd1, 10'd0, 10'd3, 10'd1023,
                                                          10'd12, 10'd0};
    localparam cfg_data_t PHASE_SHIFT    [PHASE_COUNT] = '{10'd1, 10'd0, 10'd2, 10'd1023,
                                                          10'd4, 10'd0};
    localparam cfg_data_t PHASE_DEBOUNCE [PHASE_COUNT] = '{10'd1, 10'd0, 10'd5, 10'd1023,
                                                          10'd20, 10'd0};
    localparam int        PHASE_TICKS    [PHASE_COUNT] = '{300, 250, 300, 250, 300, 300};

    typedef struct packed {
        led_t  led;
        mode_t mode;
    } led_frame_t;

    typedef struct packed {
        logic  press;
        logic  typed;
        led_t  led;
        mode_t mode;
    } dir_row_t;

    // Directed walk with debounce 1: a rejected bounce, then seven confirmed presses
    // that step through every mode and wrap to mode 1. Each released row shows the
    // first step of the new pattern.
    localparam dir_row_t DIR_ROWS [DIR_ROW_COUNT] = '{
        '{1'b0, 1'b1, ALL_ON,       MODE_FIRST},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b0, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b0, 1'b1, 32'h0000_0001, MODE_FILL_LOW},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b0, 1'b1, ALL_ON,       MODE_BLINK_B},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b0, 1'b1, TOP_BIT,      MODE_FILL_HIGH},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b0, 1'b1, 32'h8000_0001, MODE_BOTH_ENDS},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b0, 1'b1, ALL_ON,       MODE_BLINK_C},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b0, 1'b1, 32'h0001_8000, MODE_MIDDLE},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b1, 1'b0, 32'h0,        MODE_FIRST},
        '{1'b0, 1'b1, ALL_ON,       MODE_FIRST}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_wr_en;
    cfg_addr_t   cfg_addr;
    cfg_data_t   cfg_wdata;

    led_chaser_with_mode_button_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Chaser state as the testbench tracks it.
    mode_t       p_mode;
    led_t        p_led;
    led_t        p_left;
    led_t        p_right;
    int unsigned p_step;
    int unsigned p_dwell;
    int unsigned p_deb;
    phase_t      p_phase;
    dwell_t      cfg_blink;
    dwell_t      cfg_shift;
    deb_t        cfg_debounce;

    led_frame_t  expected_frames [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          fail_count;
    int          ticks_sent;
    int          frames_checked;
    int          settings_used;
    int          cycle_count;
    logic [7:0]  modes_seen;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic blink_mode(input mode_t m);
        return !(m == MODE_FILL_LOW || m == MODE_FILL_HIGH ||
                 m == MODE_BOTH_ENDS || m == MODE_MIDDLE);
    endfunction

    function automatic void load_next_step();
        int unsigned steps;
        logic        fill;
        if (blink_mode(p_mode))
            steps = 2 * BLINK_CYCLES;
        else if (p_mode == MODE_FILL_LOW || p_mode == MODE_FILL_HIGH)
            steps = 2 * LED_COUNT;
        else
            steps = 2 * HALF_COUNT;
        // The pass counter has no visible effect, so only the wrap is kept.
        if (p_step >= steps)
            p_step = 0;
        if (p_step == 0) begin
            p_led   = '0;
            p_left  = '0;
            p_right = '0;
        end
        case (p_mode)
            MODE_FILL_LOW: begin
                fill  = (p_step < LED_COUNT);
                p_led = {p_led[LED_COUNT-2:0], fill};
            end
            MODE_FILL_HIGH: begin
                fill  = (p_step < LED_COUNT);
                p_led = {fill, p_led[LED_COUNT-1:1]};
            end
            MODE_BOTH_ENDS: begin
                if (p_step < HALF_COUNT) begin
                    p_left  = {1'b1, p_left[LED_COUNT-1:1]};
                    p_right = {p_right[LED_COUNT-2:0], 1'b1};
                end else begin
                    p_left  = (p_left >> 1) & LEFT_MASK;
                    p_right = (p_right << 1) & RIGHT_MASK;
                end
                p_led = p_left | p_right;
            end
            MODE_MIDDLE: begin
                if (p_step < HALF_COUNT) begin
                    p_left  = (p_left << 1) | MID_UP;
                    p_right = (p_right >> 1) | MID_DOWN;
                end else begin
                    p_left  = (p_left << 1) & LEFT_MASK;
                    p_right = (p_right >> 1) & RIGHT_MASK;
                end
                p_led = p_left | p_right;
            end
            default: begin
                p_led = p_step[0] ? '0 : ALL_ON;
            end
        endcase
        p_step++;
    endfunction

    function automatic void pattern_tick(input logic pressed);
        int unsigned dwell;
        dwell = blink_mode(p_mode) ? 32'(cfg_blink) : 32'(cfg_shift);
        if (dwell == 0)
            dwell = 1;
        if (p_step == 0 || p_dwell >= dwell) begin
            load_next_step();
            p_dwell = 0;
        end
        if (pressed) begin
            p_phase = PH_DEBOUNCE;
            p_deb   = 0;
        end else if (p_dwell < 1023) begin
            p_dwell++;
        end
    endfunction

    function automatic led_frame_t chase_tick(input logic pressed);
        int unsigned limit;
        case (p_phase)
            PH_DEBOUNCE: begin
                limit = (cfg_debounce == 0) ? 32'd1 : 32'(cfg_debounce);
                if (p_deb < 255)
                    p_deb++;
                if (p_deb >= limit) begin
                    if (pressed) begin
                        p_mode  = (p_mode >= MODE_LAST) ? MODE_FIRST : p_mode + 3'd1;
                        p_phase = PH_RELEASE;
                    end else begin
                        // A bounce that did not hold still counts as a dwell tick.
                        p_phase = PH_IDLE;
                        if (p_dwell < 1023)
                            p_dwell++;
                    end
                end
            end
            PH_RELEASE: begin
                if (!pressed) begin
                    p_phase = PH_IDLE;
                    p_step  = 0;
                    p_dwell = 0;
                    pattern_tick(1'b0);
                end
            end
            default: begin
                p_phase = PH_IDLE;
                pattern_tick(pressed);
            end
        endcase
        return '{led: p_led, mode: p_mode};
    endfunction

    task automatic write_reg(input cfg_addr_t addr, input cfg_data_t data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        case (addr)
            CFG_BLINK_DWELL: cfg_blink    = data;
            CFG_SHIFT_DWELL: cfg_shift    = data;
            CFG_DEBOUNCE:    cfg_debounce = data[DEB_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_timing(input cfg_data_t blink, input cfg_data_t shift,
                                  input cfg_data_t debounce);
        write_reg(CFG_BLINK_DWELL, blink);
        write_reg(CFG_SHIFT_DWELL, shift);
        write_reg(CFG_DEBOUNCE, debounce);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_frames_drained();
        do @(posedge aclk); while (expected_frames.size() != 0);
    endtask

    task automatic send_tick(input logic pressed, input logic typed,
                             input led_t typed_led, input mode_t typed_mode);
        led_frame_t f;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pressed};
        do @(posedge aclk); while (!s_tready);
        f = chase_tick(pressed);
        if (typed) begin
            f.led  = typed_led;
            f.mode = typed_mode;
        end
        expected_frames.push_back(f);
        ticks_sent++;
    endtask

    // Button runs: mostly presses long enough to be confirmed, some bounces that
    // are rejected, and releases ranging from a few ticks to whole pattern passes.
    function automatic int unsigned run_length(input logic pressed);
        int unsigned deb_eff;
        int unsigned pick;
        deb_eff = (cfg_debounce == 0) ? 32'd1 : 32'(cfg_debounce);
        pick    = $urandom_range(99);
        if (pressed) begin
            if (pick < 65)
                return deb_eff + 1 + $urandom_range(0, 8);
            else if (pick < 85)
                return $urandom_range(1, deb_eff);
            else
                return deb_eff + 1 + $urandom_range(20, 120);
        end
        if (pick < 50)
            return $urandom_range(1, 6);
        else if (pick < 85)
            return $urandom_range(7, 40);
        return $urandom_range(100, 300);
    endfunction

    always @(posedge aclk) begin
        led_frame_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                modes_seen[m_tdata[34:32]] = 1'b1;
                if (expected_frames.size() == 0) begin
                    $error("result beat with no tick outstanding: led_word %h mode %0d",
                           m_tdata[31:0], m_tdata[34:32]);
                    fail_count++;
                end else begin
                    want = expected_frames.pop_front();
                    frames_checked++;
                    if (m_tdata[31:0] !== want.led) begin
                        $error("led_word: expected %h, got %h", want.led, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[34:32] !== want.mode) begin
                        $error("mode: expected %0d, got %0d", want.mode, m_tdata[34:32]);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int unsigned run_left;
        logic        level;

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        fail_count     = 0;
        ticks_sent     = 0;
        frames_checked = 0;
        settings_used  = 0;
        cycle_count    = 0;
        modes_seen     = '0;
        send_idle_pct  = 22;
        recv_stall_pct = 58;

        p_mode       = MODE_FIRST;
        p_led        = '0;
        p_left       = '0;
        p_right      = '0;
        p_step       = 0;
        p_dwell      = 0;
        p_deb        = 0;
        p_phase      = PH_IDLE;
        cfg_blink    = BLINK_DWELL_RST;
        cfg_shift    = SHIFT_DWELL_RST;
        cfg_debounce = DEBOUNCE_RST;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        program_timing(10'd2, 10'd1, 10'd1);
        for (int r = 0; r < DIR_ROW_COUNT; r++)
            send_tick(DIR_ROWS[r].press, DIR_ROWS[r].typed, DIR_ROWS[r].led, DIR_ROWS[r].mode);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_frames_drained();
            repeat (3) @(posedge aclk);
            send_idle_pct  = (ph < 2) ? 22 : (ph < 4) ? 58 : 0;
            recv_stall_pct = (ph < 2) ? 58 : (ph < 4) ? 22 : 0;
            if (ph == 1)
                write_reg(CFG_UNUSED, '1);
            if (ph == PHASE_COUNT - 1)
                program_timing(cfg_data_t'($urandom_range(1, 8)),
                               cfg_data_t'($urandom_range(1, 8)),
                               cfg_data_t'($urandom_range(1, 30)));
            else
                program_timing(PHASE_BLINK[ph], PHASE_SHIFT[ph], PHASE_DEBOUNCE[ph]);

            level    = 1'b1;
            run_left = 0;
            for (int n = 0; n < PHASE_TICKS[ph]; n++) begin
                if (run_left == 0) begin
                    level    = !level;
                    run_left = run_length(level);
                end
                // Hold the sender off once per setting until the output side is empty.
                if (n == PHASE_TICKS[ph] / 2) begin
                    s_tvalid <= 1'b0;
                    wait_frames_drained();
                end
                send_tick(level, 1'b0, '0, MODE_FIRST);
                run_left--;
            end
            s_tvalid <= 1'b0;
        end

        wait_frames_drained();
        repeat (8) @(posedge aclk);

        $display("Sent %0d button ticks under %0d timing settings; %0d LED frames compared.",
                 ticks_sent, settings_used, frames_checked);
        $display("Modes observed on the output (bit per mode number): %b", modes_seen);
        if (fail_count == 0 && expected_frames.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/lcmb_pkg.sv
sv/lcmb_pattern.sv
sv/led_chaser_with_mode_button_top.sv
bench/led_chaser_with_mode_button_top_tb.sv
